### rtl/rat_pkg.sv
// Package with shared constants and types for the rational ALU.
package rat_pkg;
  localparam int OperandWidthDefault = 16;
  localparam int NumBits = 33;
  localparam int DenBits = 32;
  localparam int MagBits = 34;
  localparam int CntBits = 6;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;
endpackage

### rtl/rat_divu.sv
// Shared restoring divider, one quotient bit per cycle.
module rat_divu
  import rat_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [MagBits-1:0] dividend,
  input  logic [MagBits-1:0] divisor,
  output logic               done,
  output logic [MagBits-1:0] quot,
  output logic [MagBits-1:0] rem
);
  logic [CntBits-1:0] cnt;
  logic               run;
  logic [MagBits-1:0] trial;

  assign trial = {rem[MagBits-2:0], quot[MagBits-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
        quot <= dividend;
        rem <= '0;
      end else if (run) begin
        if ({1'b0, trial} >= {1'b0, divisor}) begin
          rem <= trial - divisor;
          quot <= {quot[MagBits-2:0], 1'b1};
        end else begin
          rem <= trial;
          quot <= {quot[MagBits-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CntBits'(MagBits - 1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/rational_alu_with_reduction_unit.sv
// Top level of the rational ALU: shared multiplier, gcd and reduction sequencer.
// Sequence after accept: MUL1, MUL2, SUM (add and subtract only), then DONE, where the result
// is ready when it is zero or its denominator is zero; otherwise one divide per Euclid step, the
// last gcd check and two divides on the shared 34-bit restoring divider follow.
// Throughput: one item at a time; busy is low in the result cycle, so a new transfer can start.
// Reset (rst, synchronous) returns the sequencer to idle; the receiver cannot stall.
module rational_alu_with_reduction_unit
  import rat_pkg::*;
#(
  parameter int OPERAND_WIDTH = OperandWidthDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      cmd,
  input  logic signed [OPERAND_WIDTH-1:0] a_num,
  input  logic signed [OPERAND_WIDTH-1:0] a_den,
  input  logic signed [OPERAND_WIDTH-1:0] b_num,
  input  logic signed [OPERAND_WIDTH-1:0] b_den,
  output logic                            strobe,
  output logic signed [NumBits-1:0]       raw_num,
  output logic signed [DenBits-1:0]       raw_den,
  output logic signed [NumBits-1:0]       red_num,
  output logic signed [DenBits-1:0]       red_den,
  output logic                            zero_den
);
  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_MUL2, S_SUM, S_GCD, S_DIVN, S_DIVD, S_DONE
  } state_t;

  localparam int PW = 2 * OPERAND_WIDTH;

  state_t state;
  op_t op;
  logic signed [OPERAND_WIDTH-1:0] an, ad, bn, bd;
  logic signed [OPERAND_WIDTH-1:0] ma, mb;
  logic signed [PW-1:0] prod, p1;
  logic [MagBits-1:0] ga, gb, gval;
  logic [MagBits-1:0] dv_a, dv_b, quot, rem;
  logic dv_go, dv_done, dv_wait;
  logic [NumBits-1:0] sum;
  logic [MagBits-1:0] mag_n, mag_d;

  assign prod = ma * mb;
  assign mag_n = raw_num[NumBits-1] ? MagBits'(-{1'b1, raw_num}) : MagBits'(raw_num);
  assign mag_d = raw_den[DenBits-1] ? MagBits'(-{{2{1'b1}}, raw_den})
                                    : MagBits'(raw_den);

  always_comb begin
    ma = an;
    mb = bd;
    case (state)
      S_MUL1: begin
        ma = an;
        mb = (op == OP_MUL) ? bn : bd;
      end
      S_MUL2: begin
        ma = ad;
        mb = (op == OP_DIV) ? bn : bd;
      end
      S_SUM: begin
        ma = ad;
        mb = bn;
      end
      default: begin
        ma = an;
        mb = bd;
      end
    endcase
  end

  always_comb begin
    case (op)
      OP_ADD: sum = NumBits'(p1) + NumBits'(prod);
      OP_SUB: sum = NumBits'(p1) - NumBits'(prod);
      default: sum = NumBits'(p1);
    endcase
  end

  always_comb begin
    dv_a = ga;
    dv_b = gb;
    case (state)
      S_DIVN: begin
        dv_a = mag_n;
        dv_b = gval;
      end
      S_DIVD: begin
        dv_a = mag_d;
        dv_b = gval;
      end
      default: begin
        dv_a = gb;
        dv_b = ga;
      end
    endcase
  end

  rat_divu u_div (
    .clk(clk), .rst(rst), .go(dv_go), .dividend(dv_a), .divisor(dv_b),
    .done(dv_done), .quot(quot), .rem(rem)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      strobe <= 1'b0;
      dv_go <= 1'b0;
      dv_wait <= 1'b0;
    end else begin
      strobe <= 1'b0;
      dv_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op <= op_t'(cmd);
            an <= a_num;
            ad <= a_den;
            bn <= b_num;
            bd <= b_den;
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          p1 <= prod;
          state <= S_MUL2;
        end
        S_MUL2: begin
          raw_den <= DenBits'(prod);
          if (op == OP_ADD || op == OP_SUB) begin
            state <= S_SUM;
          end else begin
            raw_num <= sum;
            state <= S_DONE;
          end
        end
        S_SUM: begin
          raw_num <= sum;
          state <= S_DONE;
        end
        S_DONE: begin
          if (raw_den == '0) begin
            zero_den <= 1'b1;
            red_num <= '0;
            red_den <= '0;
            strobe <= 1'b1;
            state <= S_IDLE;
          end else if (raw_num == '0) begin
            zero_den <= 1'b0;
            red_num <= '0;
            red_den <= DenBits'(1);
            strobe <= 1'b1;
            state <= S_IDLE;
          end else begin
            zero_den <= 1'b0;
            ga <= mag_n;
            gb <= mag_d;
            dv_wait <= 1'b0;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          if (!dv_wait) begin
            if (ga == '0) begin
              gval <= gb;
              dv_go <= 1'b1;
              dv_wait <= 1'b1;
              state <= S_DIVN;
            end else begin
              dv_go <= 1'b1;
              dv_wait <= 1'b1;
            end
          end else if (dv_done) begin
            gb <= ga;
            ga <= rem;
            dv_wait <= 1'b0;
          end
        end
        S_DIVN: begin
          if (dv_done) begin
            red_num <= raw_num[NumBits-1] ? NumBits'(-quot) : NumBits'(quot);
            dv_go <= 1'b1;
            state <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (dv_done) begin
            red_den <= raw_den[DenBits-1] ? DenBits'(-quot) : DenBits'(quot);
            strobe <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |-> state == S_IDLE) else $error("strobe outside idle");
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    strobe && zero_den |-> red_num == '0 && red_den == '0)
    else $error("zero denominator result not cleared");
  a_no_double: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe) else $error("double result");
`endif
endmodule

### test/tb_rational_alu_with_reduction_unit.sv
// Testbench for the rational ALU: random and corner fractions checked against a predictor.
module tb_rational_alu_with_reduction_unit
  import rat_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [NumBits-1:0] raw_num;
    logic signed [DenBits-1:0] raw_den;
    logic signed [NumBits-1:0] red_num;
    logic signed [DenBits-1:0] red_den;
    logic zero_den;
  } fraction_t;

  class fraction_scoreboard;
    fraction_t pending[$];
    int errors = 0;

    function longint unsigned euclid(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (x != 0) begin
        t = y % x;
        y = x;
        x = t;
      end
      return y;
    endfunction

    function void note_operands(op_t op, logic signed [15:0] an, logic signed [15:0] ad,
                                logic signed [15:0] bn, logic signed [15:0] bd);
      longint sn, sd, g, mn, md;
      fraction_t f;
      case (op)
        OP_ADD: begin sn = an * bd + ad * bn; sd = ad * bd; end
        OP_SUB: begin sn = an * bd - ad * bn; sd = ad * bd; end
        OP_MUL: begin sn = an * bn; sd = ad * bd; end
        default: begin sn = an * bd; sd = ad * bn; end
      endcase
      f.raw_num = sn[NumBits-1:0];
      f.raw_den = sd[DenBits-1:0];
      sn = longint'(f.raw_num);
      sd = longint'(f.raw_den);
      f.zero_den = (sd == 0);
      if (sd == 0) begin
        f.red_num = '0;
        f.red_den = '0;
      end else if (sn == 0) begin
        f.red_num = '0;
        f.red_den = DenBits'(1);
      end else begin
        mn = sn < 0 ? -sn : sn;
        md = sd < 0 ? -sd : sd;
        g = euclid(mn, md);
        f.red_num = NumBits'(sn / g);
        f.red_den = DenBits'(sd / g);
      end
      pending.push_back(f);
    endfunction

    function void check_result(fraction_t got);
      fraction_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result raw %0d/%0d", $time, got.raw_num, got.raw_den);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.raw_num !== want.raw_num || got.raw_den !== want.raw_den
          || got.red_num !== want.red_num || got.red_den !== want.red_den
          || got.zero_den !== want.zero_den) begin
        $display("%0t: expected %0d/%0d %0d/%0d z%0b, got %0d/%0d %0d/%0d z%0b", $time,
                 want.raw_num, want.raw_den, want.red_num, want.red_den, want.zero_den,
                 got.raw_num, got.raw_den, got.red_num, got.red_den, got.zero_den);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, strobe, zero_den;
  logic [1:0] cmd = '0;
  logic signed [15:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  logic signed [NumBits-1:0] raw_num, red_num;
  logic signed [DenBits-1:0] raw_den, red_den;
  fraction_scoreboard board = new();
  int idle_pct = 21;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  rational_alu_with_reduction_unit dut (.*);

  always @(posedge clk) begin
    if (!rst && strobe)
      board.check_result('{raw_num, raw_den, red_num, red_den, zero_den});
    if ((start && !busy) || strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(op_t op, logic [15:0] an, logic [15:0] ad,
                           logic [15:0] bn, logic [15:0] bd);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    cmd <= op;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    do @(posedge clk); while (busy);
    board.note_operands(op, an, ad, bn, bd);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(8)) - 16'd4;
      3: return 16'($urandom_range(60));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(int count);
    repeat (count)
      send_item(op_t'($urandom_range(3)), pick_value(), pick_value(),
                pick_value(), pick_value());
    start <= 0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int op = 0; op < 4; op++) begin
      send_item(op_t'(op), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_item(op_t'(op), 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
      send_item(op_t'(op), 16'd0, 16'd5, 16'd0, 16'd7);
      send_item(op_t'(op), 16'd6, 16'hfff7, 16'd4, 16'd0);
      send_item(op_t'(op), 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    end
    send_item(OP_SUB, 16'd3, 16'd4, 16'd3, 16'd4);
    send_item(OP_DIV, 16'd1, 16'd2, 16'd0, 16'd3);
    send_random(200);
    while (board.pending.size() != 0) @(posedge clk);
    idle_pct = 70;
    send_random(200);
    idle_pct = 0;
    send_random(230);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

### rational_alu_with_reduction_unit.f
rtl/rat_pkg.sv
rtl/rat_divu.sv
rtl/rational_alu_with_reduction_unit.sv
test/tb_rational_alu_with_reduction_unit.sv
